/* src/lru_pr_pkg.sv */
// Shared constants and types for the LRU page replacement block.
package lru_pr_pkg;

  // Default geometry
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CFG_W   = 5;
  localparam int FAULT_W = 32;

  // frames_in_use after reset
  localparam logic [CFG_W-1:0] LIMIT_RST = 5'd16;

  // Outcome of one reference, store to top level
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

endpackage

/* src/lru_pr_store.sv */
// Frame store: tag compare, free-frame and victim select, recency ages.
module lru_pr_store #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         upd_en,
  input  logic [PAGE_BITS-1:0]         page,
  input  logic [lru_pr_pkg::CFG_W-1:0] cfg_limit,
  output lru_pr_pkg::lookup_t          res,
  output logic [PAGE_BITS-1:0]         ev_page
);

  localparam int AGE_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > lru_pr_pkg::CFG_W) ? CNT_W : lru_pr_pkg::CFG_W;

  logic [PAGE_BITS-1:0] frame_page_r [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r, frame_valid_nxt;
  logic [AGE_W-1:0]     frame_age_r [FRAMES];
  logic [AGE_W-1:0]     frame_age_nxt [FRAMES];
  logic [CNT_W-1:0]     occ_r, occ_nxt;

  logic [LIM_W-1:0] lim;
  logic [CNT_W-1:0] occ_m1;
  logic [FRAMES-1:0] match, oldest;
  logic [AGE_W-1:0] hit_idx, free_idx, vic_idx, slot, thr;
  logic             hit, free_ok, age_all;

  // Effective limit: zero acts as one, clamp at FRAMES
  always_comb begin
    lim = LIM_W'(cfg_limit);
    if (lim == '0) begin
      lim = LIM_W'(1);
    end
    if (lim > LIM_W'(FRAMES)) begin
      lim = LIM_W'(FRAMES);
    end
  end

  assign occ_m1  = occ_r - CNT_W'(1);
  assign free_ok = LIM_W'(occ_r) < lim;

  // Parallel compare; valid ages are 0..occ-1, so the oldest is unique
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = frame_valid_r[i] && (frame_page_r[i] == page);
      oldest[i] = frame_valid_r[i] && (frame_age_r[i] == AGE_W'(occ_m1));
    end
  end

  // Priority encoders, lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = AGE_W'(i);
      end
      if (!frame_valid_r[i]) begin
        free_idx = AGE_W'(i);
      end
      if (oldest[i]) begin
        vic_idx = AGE_W'(i);
      end
    end
  end

  assign hit = |match;

  // Pick target frame and aging threshold
  always_comb begin
    res.hit   = hit;
    res.evict = 1'b0;
    ev_page   = '0;
    occ_nxt   = occ_r;
    age_all   = 1'b0;
    if (hit) begin
      slot = hit_idx;
      thr  = frame_age_r[hit_idx];
    end else if (free_ok) begin
      slot    = free_idx;
      thr     = '0;
      age_all = 1'b1;
      occ_nxt = occ_r + CNT_W'(1);
    end else begin
      slot      = vic_idx;
      thr       = AGE_W'(occ_m1);
      res.evict = 1'b1;
      ev_page   = frame_page_r[vic_idx];
    end
  end

  // Age every younger valid frame, target becomes most recent
  always_comb begin
    frame_valid_nxt = frame_valid_r;
    for (int i = 0; i < FRAMES; i++) begin
      frame_age_nxt[i] = frame_age_r[i];
      if (frame_valid_r[i] && (age_all || frame_age_r[i] < thr)) begin
        frame_age_nxt[i] = frame_age_r[i] + AGE_W'(1);
      end
      if (slot == AGE_W'(i)) begin
        frame_age_nxt[i]   = '0;
        frame_valid_nxt[i] = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      occ_r         <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_age_r[i] <= '0;
      end
    end else if (upd_en) begin
      frame_valid_r <= frame_valid_nxt;
      occ_r         <= occ_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        frame_age_r[i] <= frame_age_nxt[i];
      end
    end
  end

  // Page tags, no reset
  always_ff @(posedge clk) begin
    if (upd_en) begin
      frame_page_r[slot] <= page;
    end
  end

endmodule

/* src/lru_page_replacement.sv */
// Top level of the LRU page replacement block.
//
// Usage: each transfer on the in_ channel carries one page number; each
// transfer on the out_ channel returns exactly one result for it, in order:
// hit flag, eviction flag, evicted page (zero when none) and the running,
// saturating page-fault count. cfg_wr_en/cfg_wr_data set frames_in_use
// (zero acts as one, values above FRAMES act as FRAMES); write it only
// while no reference is in flight.
// Path: a reference passes the input register, then the output register,
// before its result is offered on the out_ channel. Throughput: one
// reference per cycle while out_tready is high; the lookup and the
// recency update of the whole frame store are combinational between the
// two registers.
// Reset: all frames empty, fault count zero, frames_in_use = 16.
// Stall: while out_tready is low the result holds; one more reference is
// taken into the input register, then in_tready drops until the result
// leaves. The store is updated only when a reference moves to the output.
module lru_page_replacement #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]        in_tdata,   // page_number
  // Result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((PAGE_BITS+41)/8)*8-1:0]       out_tdata,  // hit, evicted_valid,
                                                            // evicted_page, fault_total
  // Configuration
  input  logic                                  cfg_wr_en,
  input  logic [lru_pr_pkg::CFG_W-1:0]          cfg_wr_data
);

  localparam int OUT_W   = ((PAGE_BITS + 41) / 8) * 8;
  localparam int FAULT_W = lru_pr_pkg::FAULT_W;

  logic [lru_pr_pkg::CFG_W-1:0] limit_r;
  logic                         s1_valid_r;
  logic [PAGE_BITS-1:0]         s1_page_r;
  logic                         s1_adv, upd_en;
  logic                         out_valid_r;
  logic [OUT_W-1:0]             out_data_r, out_data_nxt;
  logic [FAULT_W-1:0]           fault_r, fault_nxt;
  lru_pr_pkg::lookup_t          res;
  logic [PAGE_BITS-1:0]         ev_page;

  // Handshake: input stage moves on when the output register is free
  assign s1_adv    = !out_valid_r || out_tready;
  assign upd_en    = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lru_pr_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_page_r <= in_tdata[PAGE_BITS-1:0];
    end
  end

  lru_pr_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (upd_en),
    .page      (s1_page_r),
    .cfg_limit (limit_r),
    .res       (res),
    .ev_page   (ev_page)
  );

  // Saturating fault count, includes this reference
  always_comb begin
    fault_nxt = fault_r;
    if (!res.hit && (fault_r != {FAULT_W{1'b1}})) begin
      fault_nxt = fault_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (upd_en) begin
      fault_r <= fault_nxt;
    end
  end

  // Result packing
  always_comb begin
    out_data_nxt                            = '0;
    out_data_nxt[0]                         = res.hit;
    out_data_nxt[1]                         = res.evict;
    out_data_nxt[2 +: PAGE_BITS]            = ev_page;
    out_data_nxt[2 + PAGE_BITS +: FAULT_W]  = fault_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* tb/lru_page_replacement_test.sv */
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

module lru_page_replacement_test;

  localparam int NFRAMES = 16;
  localparam int PAGE_W  = 16;

  // One result, packed as on out_tdata: hit at bit 0 upward
  typedef struct packed {
    logic [lru_pr_pkg::FAULT_W-1:0] faults;
    logic [PAGE_W-1:0]              ev_page;
    logic                           ev_valid;
    logic                           hit;
  } lookup_result_t;

  typedef enum logic { ROW_REF, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic [15:0]    value;   // page, or frames_in_use in the low bits
    bit             typed;   // expectation typed in below
    lookup_result_t want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [15:0]                  in_tdata;    // page_number
  logic                         out_tvalid;
  logic                         out_tready;
  logic [55:0]                  out_tdata;   // hit, evicted_valid, evicted_page, fault_total
  logic                         cfg_wr_en;
  logic [lru_pr_pkg::CFG_W-1:0] cfg_wr_data;

  always #4 clk = ~clk;

  lru_page_replacement #(
    .FRAMES   (NFRAMES),
    .PAGE_BITS(PAGE_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the frame store
  logic [PAGE_W-1:0]              frame_pg   [NFRAMES];
  bit                             frame_used [NFRAMES];
  logic [3:0]                     frame_rank [NFRAMES];   // 0 = most recent
  logic [4:0]                     resident;
  logic [lru_pr_pkg::FAULT_W-1:0] fault_cnt;
  logic [lru_pr_pkg::CFG_W-1:0]   limit_reg;

  lookup_result_t pending_results[$];
  int             mismatches;
  bit             no_idle;

  // Directed part: extremes, limit zero, limit above FRAMES, limit below occupancy
  dir_row_t dir_rows [29] = '{
    '{ROW_REF, 16'h0000, 1'b1, '{32'd1, 16'h0000, 1'b0, 1'b0}},
    '{ROW_REF, 16'hFFFF, 1'b1, '{32'd2, 16'h0000, 1'b0, 1'b0}},
    '{ROW_REF, 16'h0000, 1'b1, '{32'd2, 16'h0000, 1'b0, 1'b1}},
    '{ROW_CFG, 16'd1,    1'b0, '0},
    '{ROW_REF, 16'h1234, 1'b1, '{32'd3, 16'hFFFF, 1'b1, 1'b0}},
    '{ROW_REF, 16'h0000, 1'b1, '{32'd3, 16'h0000, 1'b0, 1'b1}},
    '{ROW_REF, 16'hAAAA, 1'b1, '{32'd4, 16'h1234, 1'b1, 1'b0}},
    '{ROW_CFG, 16'd0,    1'b0, '0},
    '{ROW_REF, 16'h5555, 1'b1, '{32'd5, 16'h0000, 1'b1, 1'b0}},
    '{ROW_REF, 16'h5555, 1'b1, '{32'd5, 16'h0000, 1'b0, 1'b1}},
    '{ROW_CFG, 16'd31,   1'b0, '0},
    '{ROW_REF, 16'h8000, 1'b0, '0},
    '{ROW_REF, 16'h8001, 1'b0, '0},
    '{ROW_REF, 16'h8002, 1'b0, '0},
    '{ROW_REF, 16'h8003, 1'b0, '0},
    '{ROW_REF, 16'h8004, 1'b0, '0},
    '{ROW_REF, 16'h8005, 1'b0, '0},
    '{ROW_REF, 16'h8006, 1'b0, '0},
    '{ROW_REF, 16'h8007, 1'b0, '0},
    '{ROW_REF, 16'h8008, 1'b0, '0},
    '{ROW_REF, 16'h8009, 1'b0, '0},
    '{ROW_REF, 16'h800A, 1'b0, '0},
    '{ROW_REF, 16'h800B, 1'b0, '0},
    '{ROW_REF, 16'h800C, 1'b0, '0},
    '{ROW_REF, 16'h800D, 1'b0, '0},
    '{ROW_REF, 16'h7FFF, 1'b0, '0},
    '{ROW_CFG, 16'd16,   1'b0, '0},
    '{ROW_REF, 16'h8000, 1'b0, '0},
    '{ROW_REF, 16'h0F0F, 1'b0, '0}
  };

  // Zero acts as one, anything above FRAMES as FRAMES
  function automatic int unsigned cap_of(input logic [lru_pr_pkg::CFG_W-1:0] lim);
    if (lim == 0) return 1;
    if (lim > NFRAMES) return NFRAMES;
    return 32'(lim);
  endfunction

  // Every valid frame younger than the given age gets one step older
  function automatic void grow_older(input int unsigned below);
    for (int i = 0; i < NFRAMES; i++)
      if (frame_used[i] && frame_rank[i] < below) frame_rank[i]++;
  endfunction

  // Look one page up in the shadow store, update it, return the result
  function automatic lookup_result_t lru_lookup(input logic [PAGE_W-1:0] page);
    lookup_result_t r;
    int             slot;
    bit             found;
    bit             have_free;
    int unsigned    oldest;
    r         = '0;
    slot      = 0;
    found     = 1'b0;
    have_free = 1'b0;
    oldest    = 0;
    for (int i = 0; i < NFRAMES; i++)
      if (!found && frame_used[i] && frame_pg[i] == page) begin
        slot  = i;
        found = 1'b1;
      end
    if (found) begin
      r.hit = 1'b1;
      grow_older(frame_rank[slot]);
    end else begin
      if (fault_cnt != '1) fault_cnt++;
      if (resident < cap_of(limit_reg))
        for (int i = 0; i < NFRAMES; i++)
          if (!have_free && !frame_used[i]) begin
            slot      = i;
            have_free = 1'b1;
          end
      if (have_free) begin
        grow_older(32'hFFFF_FFFF);
        resident++;
      end else begin
        // store is full here, so some frame is valid; first oldest wins
        slot = -1;
        for (int i = 0; i < NFRAMES; i++)
          if (frame_used[i] && (slot < 0 || frame_rank[i] > oldest)) begin
            oldest = frame_rank[i];
            slot   = i;
          end
        r.ev_valid = 1'b1;
        r.ev_page  = frame_pg[slot];
        grow_older(oldest);
      end
      frame_pg[slot]   = page;
      frame_used[slot] = 1'b1;
    end
    frame_rank[slot] = '0;
    r.faults = fault_cnt;
    return r;
  endfunction

  // Send one page; the expectation is queued at the accepting edge
  task automatic send_page(input logic [15:0] page, input bit typed,
                           input lookup_result_t want);
    int             gap;
    lookup_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    do @(posedge clk); while (!in_tready);
    pred = lru_lookup(page);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Drain the block, then write frames_in_use
  task automatic set_limit(input logic [lru_pr_pkg::CFG_W-1:0] lim);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = lim;
  endtask

  function automatic void report(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    mismatches++;
  endfunction

  // Result side: random stall per result
  initial begin
    int w;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 7);
      if (w != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[49:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) report("hit", 32'(want.hit), 32'(got.hit));
        if (got.ev_valid !== want.ev_valid)
          report("evicted_valid", 32'(want.ev_valid), 32'(got.ev_valid));
        if (got.ev_page !== want.ev_page)
          report("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
        if (got.faults !== want.faults) report("fault_total", want.faults, got.faults);
      end
    end
  end

  // Stimulus
  initial begin
    logic [PAGE_W-1:0]            pool [24];
    int                           pool_n;
    int                           n;
    int                           sent;
    logic [lru_pr_pkg::CFG_W-1:0] lim;
    logic [PAGE_W-1:0]            page;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    no_idle     = 1'b0;
    mismatches  = 0;
    resident    = '0;
    fault_cnt   = '0;
    limit_reg   = lru_pr_pkg::LIMIT_RST;
    for (int i = 0; i < NFRAMES; i++) begin
      frame_pg[i]   = '0;
      frame_used[i] = 1'b0;
      frame_rank[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG)
        set_limit(dir_rows[k].value[lru_pr_pkg::CFG_W-1:0]);
      else
        send_page(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases: a limit, then references drawn mostly from a small working set
    sent = 0;
    while (sent < 1300) begin
      case ($urandom_range(0, 5))
        0:       lim = 5'd0;
        1:       lim = 5'd16;
        2:       lim = lru_pr_pkg::CFG_W'($urandom_range(17, 31));
        default: lim = lru_pr_pkg::CFG_W'($urandom_range(1, 16));
      endcase
      set_limit(lim);
      no_idle = ($urandom_range(0, 3) == 0);
      pool_n  = $urandom_range(1, cap_of(lim) + 6);
      for (int i = 0; i < pool_n; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));
      n = $urandom_range(40, 120);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom_range(0, 65535));
        else page = pool[$urandom_range(0, pool_n - 1)];
        send_page(page, 1'b0, '0);
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
